// ===== rtl/core/bci_pkg.sv =====
// Shared types, constants and the multiply-accumulate program of the color interpolator.
`default_nettype none

package bci_pkg;

    localparam int COORD_BITS_C       = 16;
    localparam int WEIGHT_FRAC_BITS_C = 16;
    localparam int POS_W              = 16;
    localparam int COLOR_W            = 24;
    localparam int CHAN_W             = 8;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
    localparam int NUM_STEPS          = 33;
    localparam int STEP_W             = 6;

    typedef enum logic
    {
        FUNC_LOAD,
        FUNC_QUERY
    } func_t;

    typedef enum logic
    {
        STATUS_OK,
        STATUS_DEGENERATE
    } status_t;

    typedef struct packed
    {
        func_t               func;
        logic [1:0]          vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [COLOR_W-1:0]  vertex_color;
    } item_t;

    typedef struct packed
    {
        logic [COLOR_W-1:0] pixel_color;
        status_t            status;
    } result_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MAC,
        ST_NX,
        ST_DIV,
        ST_MIX,
        ST_DONE
    } state_t;

    typedef enum logic [3:0]
    {
        OPD_DU0,
        OPD_DU1,
        OPD_DU2,
        OPD_DV0,
        OPD_DV1,
        OPD_DV2,
        OPD_DW0,
        OPD_DW1,
        OPD_DW2,
        OPD_UU,
        OPD_VV,
        OPD_UV,
        OPD_WU,
        OPD_WV
    } opd_t;

    typedef enum logic [3:0]
    {
        DST_NONE,
        DST_UU,
        DST_VV,
        DST_UV,
        DST_WU,
        DST_WV,
        DST_DEN,
        DST_NY,
        DST_NZ
    } dst_t;

    typedef struct packed
    {
        opd_t       a_sel;
        opd_t       b_sel;
        logic [1:0] digit;
        logic       clr;
        logic       sub;
        dst_t       dst;
    } step_t;

    function automatic step_t mk_step(opd_t a, opd_t b, logic [1:0] k, logic clr,
                                      logic sub, dst_t d);
        step_t s;
        s.a_sel = a;
        s.b_sel = b;
        s.digit = k;
        s.clr   = clr;
        s.sub   = sub;
        s.dst   = d;
        return s;
    endfunction

    function automatic step_t prog(logic [STEP_W-1:0] idx);
        step_t s;
        case (idx)
            6'd0:    s = mk_step(OPD_DU0, OPD_DU0, 2'd0, 1'b1, 1'b0, DST_NONE);
            6'd1:    s = mk_step(OPD_DU1, OPD_DU1, 2'd0, 1'b0, 1'b0, DST_NONE);
            6'd2:    s = mk_step(OPD_DU2, OPD_DU2, 2'd0, 1'b0, 1'b0, DST_UU);
            6'd3:    s = mk_step(OPD_DV0, OPD_DV0, 2'd0, 1'b1, 1'b0, DST_NONE);
            6'd4:    s = mk_step(OPD_DV1, OPD_DV1, 2'd0, 1'b0, 1'b0, DST_NONE);
            6'd5:    s = mk_step(OPD_DV2, OPD_DV2, 2'd0, 1'b0, 1'b0, DST_VV);
            6'd6:    s = mk_step(OPD_DU0, OPD_DV0, 2'd0, 1'b1, 1'b0, DST_NONE);
            6'd7:    s = mk_step(OPD_DU1, OPD_DV1, 2'd0, 1'b0, 1'b0, DST_NONE);
            6'd8:    s = mk_step(OPD_DU2, OPD_DV2, 2'd0, 1'b0, 1'b0, DST_UV);
            6'd9:    s = mk_step(OPD_DW0, OPD_DU0, 2'd0, 1'b1, 1'b0, DST_NONE);
            6'd10:   s = mk_step(OPD_DW1, OPD_DU1, 2'd0, 1'b0, 1'b0, DST_NONE);
            6'd11:   s = mk_step(OPD_DW2, OPD_DU2, 2'd0, 1'b0, 1'b0, DST_WU);
            6'd12:   s = mk_step(OPD_DW0, OPD_DV0, 2'd0, 1'b1, 1'b0, DST_NONE);
            6'd13:   s = mk_step(OPD_DW1, OPD_DV1, 2'd0, 1'b0, 1'b0, DST_NONE);
            6'd14:   s = mk_step(OPD_DW2, OPD_DV2, 2'd0, 1'b0, 1'b0, DST_WV);
            6'd15:   s = mk_step(OPD_UU, OPD_VV, 2'd0, 1'b1, 1'b0, DST_NONE);
            6'd16:   s = mk_step(OPD_UU, OPD_VV, 2'd1, 1'b0, 1'b0, DST_NONE);
            6'd17:   s = mk_step(OPD_UU, OPD_VV, 2'd2, 1'b0, 1'b0, DST_NONE);
            6'd18:   s = mk_step(OPD_UV, OPD_UV, 2'd0, 1'b0, 1'b1, DST_NONE);
            6'd19:   s = mk_step(OPD_UV, OPD_UV, 2'd1, 1'b0, 1'b1, DST_NONE);
            6'd20:   s = mk_step(OPD_UV, OPD_UV, 2'd2, 1'b0, 1'b1, DST_DEN);
            6'd21:   s = mk_step(OPD_WU, OPD_VV, 2'd0, 1'b1, 1'b0, DST_NONE);
            6'd22:   s = mk_step(OPD_WU, OPD_VV, 2'd1, 1'b0, 1'b0, DST_NONE);
            6'd23:   s = mk_step(OPD_WU, OPD_VV, 2'd2, 1'b0, 1'b0, DST_NONE);
            6'd24:   s = mk_step(OPD_WV, OPD_UV, 2'd0, 1'b0, 1'b1, DST_NONE);
            6'd25:   s = mk_step(OPD_WV, OPD_UV, 2'd1, 1'b0, 1'b1, DST_NONE);
            6'd26:   s = mk_step(OPD_WV, OPD_UV, 2'd2, 1'b0, 1'b1, DST_NY);
            6'd27:   s = mk_step(OPD_WV, OPD_UU, 2'd0, 1'b1, 1'b0, DST_NONE);
            6'd28:   s = mk_step(OPD_WV, OPD_UU, 2'd1, 1'b0, 1'b0, DST_NONE);
            6'd29:   s = mk_step(OPD_WV, OPD_UU, 2'd2, 1'b0, 1'b0, DST_NONE);
            6'd30:   s = mk_step(OPD_WU, OPD_UV, 2'd0, 1'b0, 1'b1, DST_NONE);
            6'd31:   s = mk_step(OPD_WU, OPD_UV, 2'd1, 1'b0, 1'b1, DST_NONE);
            6'd32:   s = mk_step(OPD_WU, OPD_UV, 2'd2, 1'b0, 1'b1, DST_NZ);
            default: s = mk_step(OPD_DU0, OPD_DU0, 2'd0, 1'b1, 1'b0, DST_NONE);
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bci_wdiv.sv =====
// Serial restoring divider producing one clamped fixed-point weight.
`default_nettype none

module bci_wdiv
    import bci_pkg::*;
#(
    parameter int ACC_W            = 72,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_C
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [ACC_W-1:0]       num,
    input  wire logic signed [ACC_W-1:0]       den,
    output logic                               done,
    output logic [WEIGHT_FRAC_BITS:0]          weight
);

    localparam int CNT_W = $clog2(WEIGHT_FRAC_BITS + 1);
    localparam logic [WEIGHT_FRAC_BITS:0] ONE = (WEIGHT_FRAC_BITS+1)'(1) << WEIGHT_FRAC_BITS;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [ACC_W-1:0]            rem_reg, rem_next;
    logic [WEIGHT_FRAC_BITS:0]   q_reg, q_next;
    logic [ACC_W-1:0]            rem_shl;
    logic                        ge;

    always_comb
    begin
        rem_shl   = {rem_reg[ACC_W-2:0], 1'b0};
        ge        = rem_shl >= $unsigned(den);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            if (num[ACC_W-1] || num == '0)
            begin
                q_next    = '0;
                done_next = 1'b1;
            end
            else if (num >= den)
            begin
                q_next    = ONE;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = $unsigned(num);
                q_next    = '0;
                cnt_next  = CNT_W'(WEIGHT_FRAC_BITS);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_shl - $unsigned(den) : rem_shl;
            q_next   = {q_reg[WEIGHT_FRAC_BITS-1:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done   = done_reg;
    assign weight = q_reg;

endmodule

`default_nettype wire

// ===== rtl/core/barycentric_color_interpolator.sv =====
// Top level: corner store, multiply-accumulate sequencer, weight divider and color mixer.
// Load word: written to the corner store, no result word.
// Query word: the result follows the 33-step program on the shared multiplier, the divider
// (one quotient bit per cycle, skipped for a clamped weight) and nine mixer steps; a degenerate
// triangle skips the divider and the mixer.
// One query in flight; stall is high from acceptance until the result is registered.
// Reset: corners and colors clear to zero (queries then report degenerate), no result held.
`default_nettype none

module barycentric_color_interpolator
    import bci_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_C,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_C
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    localparam int C      = COORD_BITS;
    localparam int DW     = C + 1;
    localparam int DOT_W  = 2 * C + 3;
    localparam int ACC_W  = 2 * DOT_W + 2;
    localparam int DIGITS = (DOT_W + DW - 1) / DW;
    localparam int MAGB_W = DIGITS * DW;
    localparam int PROD_W = DOT_W + DW;
    localparam int WT_W   = WEIGHT_FRAC_BITS + 1;
    localparam int MIX_W  = CHAN_W + WT_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    state_t state_reg, state_next;

    logic signed [C-1:0] px, py, pz;
    logic signed [C-1:0] cx_reg [3];
    logic signed [C-1:0] cy_reg [3];
    logic signed [C-1:0] cz_reg [3];
    logic [COLOR_W-1:0]  ccol_reg [3];

    logic signed [DW-1:0] du_reg [3];
    logic signed [DW-1:0] dv_reg [3];
    logic signed [DW-1:0] dw_reg [3];

    logic signed [DOT_W-1:0] uu_reg, vv_reg, uv_reg, wu_reg, wv_reg;
    logic signed [ACC_W-1:0] den_reg, ny_reg, nz_reg, nx_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    deg_reg;

    logic [STEP_W-1:0] step_reg;
    step_t             cur;

    logic signed [DOT_W-1:0] opa, opb;
    logic [DOT_W-1:0]        mag_a, mag_b;
    logic [MAGB_W-1:0]       mag_b_ext;
    logic [DW-1:0]           digit;
    logic [PROD_W-1:0]       prod;
    logic [ACC_W-1:0]        shifted;
    logic signed [ACC_W-1:0] term;
    logic                    neg;

    logic                    div_start, div_done, pend_reg;
    logic [WT_W-1:0]         div_q;
    logic [WT_W-1:0]         wt_reg [3];
    logic [1:0]              wi_reg;
    logic signed [ACC_W-1:0] div_num;

    logic [1:0]          ch_reg, cor_reg;
    logic [9:0]          sum_reg, sum_next;
    logic [CHAN_W-1:0]   chan, sat;
    logic [WT_W-1:0]     wsel;
    logic [MIX_W-1:0]    mix_prod;
    logic [COLOR_W-1:0]  color_reg;

    logic    out_valid_reg;
    result_t out_word_reg;

    logic accept, load_acc, query_acc, mac_run, mix_run, finish;

    if (C >= POS_W)
    begin : g_wide
        assign px = C'(item.pos_x);
        assign py = C'(item.pos_y);
        assign pz = C'(item.pos_z);
    end
    else
    begin : g_narrow
        assign px = item.pos_x[C-1:0];
        assign py = item.pos_y[C-1:0];
        assign pz = item.pos_z[C-1:0];
    end

    assign accept    = item_valid && !item_stall;
    assign load_acc  = accept && item.func == FUNC_LOAD;
    assign query_acc = accept && item.func == FUNC_QUERY;
    assign cur       = prog(step_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (query_acc) state_next = ST_MAC;
            ST_MAC:  if (step_reg == LAST_STEP) state_next = ST_NX;
            ST_NX:   state_next = (den_reg[ACC_W-1] || den_reg == '0) ? ST_DONE : ST_DIV;
            ST_DIV:  if (div_done && wi_reg == 2'd2) state_next = ST_MIX;
            ST_MIX:  if (ch_reg == 2'd2 && cor_reg == 2'd2) state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg || !result_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item_stall = 1'b1;
        mac_run    = 1'b0;
        div_start  = 1'b0;
        mix_run    = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE: item_stall = 1'b0;
            ST_MAC:  mac_run = 1'b1;
            ST_DIV:  div_start = !pend_reg;
            ST_MIX:  mix_run = 1'b1;
            ST_DONE: finish = !out_valid_reg || !result_stall;
            default: item_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        case (cur.a_sel)
            OPD_DU0: opa = DOT_W'(du_reg[0]);
            OPD_DU1: opa = DOT_W'(du_reg[1]);
            OPD_DU2: opa = DOT_W'(du_reg[2]);
            OPD_DV0: opa = DOT_W'(dv_reg[0]);
            OPD_DV1: opa = DOT_W'(dv_reg[1]);
            OPD_DV2: opa = DOT_W'(dv_reg[2]);
            OPD_DW0: opa = DOT_W'(dw_reg[0]);
            OPD_DW1: opa = DOT_W'(dw_reg[1]);
            OPD_DW2: opa = DOT_W'(dw_reg[2]);
            OPD_UU:  opa = uu_reg;
            OPD_VV:  opa = vv_reg;
            OPD_UV:  opa = uv_reg;
            OPD_WU:  opa = wu_reg;
            OPD_WV:  opa = wv_reg;
            default: opa = '0;
        endcase
        case (cur.b_sel)
            OPD_DU0: opb = DOT_W'(du_reg[0]);
            OPD_DU1: opb = DOT_W'(du_reg[1]);
            OPD_DU2: opb = DOT_W'(du_reg[2]);
            OPD_DV0: opb = DOT_W'(dv_reg[0]);
            OPD_DV1: opb = DOT_W'(dv_reg[1]);
            OPD_DV2: opb = DOT_W'(dv_reg[2]);
            OPD_DW0: opb = DOT_W'(dw_reg[0]);
            OPD_DW1: opb = DOT_W'(dw_reg[1]);
            OPD_DW2: opb = DOT_W'(dw_reg[2]);
            OPD_UU:  opb = uu_reg;
            OPD_VV:  opb = vv_reg;
            OPD_UV:  opb = uv_reg;
            OPD_WU:  opb = wu_reg;
            OPD_WV:  opb = wv_reg;
            default: opb = '0;
        endcase
    end

    // shared multiply-accumulate: one digit of b per cycle
    always_comb
    begin
        mag_a     = opa[DOT_W-1] ? $unsigned(-opa) : $unsigned(opa);
        mag_b     = opb[DOT_W-1] ? $unsigned(-opb) : $unsigned(opb);
        mag_b_ext = MAGB_W'(mag_b);
        digit     = DW'(mag_b_ext >> (32'(cur.digit) * DW));
        prod      = PROD_W'(mag_a) * PROD_W'(digit);
        shifted   = ACC_W'(prod) << (32'(cur.digit) * DW);
        neg       = opa[DOT_W-1] ^ opb[DOT_W-1] ^ cur.sub;
        term      = neg ? -$signed(shifted) : $signed(shifted);
        acc_next  = (cur.clr ? '0 : acc_reg) + term;
    end

    always_comb
    begin
        case (wi_reg)
            2'd1:    div_num = ny_reg;
            2'd2:    div_num = nz_reg;
            default: div_num = nx_reg;
        endcase
    end

    bci_wdiv #(
        .ACC_W            (ACC_W),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_wdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (den_reg),
        .done   (div_done),
        .weight (div_q)
    );

    // channel mixer: one corner channel per cycle
    always_comb
    begin
        case (cor_reg)
            2'd1:    begin wsel = wt_reg[1]; chan = CHAN_W'(ccol_reg[1] >> (32'(ch_reg) * CHAN_W)); end
            2'd2:    begin wsel = wt_reg[2]; chan = CHAN_W'(ccol_reg[2] >> (32'(ch_reg) * CHAN_W)); end
            default: begin wsel = wt_reg[0]; chan = CHAN_W'(ccol_reg[0] >> (32'(ch_reg) * CHAN_W)); end
        endcase
        mix_prod = MIX_W'(chan) * MIX_W'(wsel);
        sum_next = (cor_reg == 2'd0 ? 10'd0 : sum_reg) + 10'(mix_prod >> WEIGHT_FRAC_BITS);
        sat      = (sum_next > 10'(CHAN_MAX)) ? CHAN_MAX : sum_next[CHAN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            pend_reg      <= 1'b0;
            wi_reg        <= '0;
            ch_reg        <= '0;
            cor_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cx_reg[i]   <= '0;
                cy_reg[i]   <= '0;
                cz_reg[i]   <= '0;
                ccol_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_acc)
            begin
                case (item.vertex_index)
                    2'd0:
                    begin
                        cx_reg[0] <= px; cy_reg[0] <= py; cz_reg[0] <= pz;
                        ccol_reg[0] <= item.vertex_color;
                    end
                    2'd1:
                    begin
                        cx_reg[1] <= px; cy_reg[1] <= py; cz_reg[1] <= pz;
                        ccol_reg[1] <= item.vertex_color;
                    end
                    2'd2:
                    begin
                        cx_reg[2] <= px; cy_reg[2] <= py; cz_reg[2] <= pz;
                        ccol_reg[2] <= item.vertex_color;
                    end
                    default:
                    begin
                        cx_reg[0] <= cx_reg[0];
                    end
                endcase
            end
            if (query_acc)
                step_reg <= '0;
            else if (mac_run)
                step_reg <= step_reg + STEP_W'(1);
            if (state_reg == ST_NX)
            begin
                wi_reg   <= '0;
                pend_reg <= 1'b0;
                ch_reg   <= '0;
                cor_reg  <= '0;
            end
            if (div_start)
                pend_reg <= 1'b1;
            else if (div_done)
            begin
                pend_reg <= 1'b0;
                wi_reg   <= wi_reg + 2'd1;
            end
            if (mix_run)
            begin
                if (cor_reg == 2'd2)
                begin
                    cor_reg <= '0;
                    ch_reg  <= ch_reg + 2'd1;
                end
                else
                    cor_reg <= cor_reg + 2'd1;
            end
            if (finish)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            du_reg[0] <= DW'(cx_reg[1]) - DW'(cx_reg[0]);
            du_reg[1] <= DW'(cy_reg[1]) - DW'(cy_reg[0]);
            du_reg[2] <= DW'(cz_reg[1]) - DW'(cz_reg[0]);
            dv_reg[0] <= DW'(cx_reg[2]) - DW'(cx_reg[0]);
            dv_reg[1] <= DW'(cy_reg[2]) - DW'(cy_reg[0]);
            dv_reg[2] <= DW'(cz_reg[2]) - DW'(cz_reg[0]);
            dw_reg[0] <= DW'(px) - DW'(cx_reg[0]);
            dw_reg[1] <= DW'(py) - DW'(cy_reg[0]);
            dw_reg[2] <= DW'(pz) - DW'(cz_reg[0]);
        end
        if (mac_run)
        begin
            acc_reg <= acc_next;
            case (cur.dst)
                DST_UU:  uu_reg  <= acc_next[DOT_W-1:0];
                DST_VV:  vv_reg  <= acc_next[DOT_W-1:0];
                DST_UV:  uv_reg  <= acc_next[DOT_W-1:0];
                DST_WU:  wu_reg  <= acc_next[DOT_W-1:0];
                DST_WV:  wv_reg  <= acc_next[DOT_W-1:0];
                DST_DEN: den_reg <= acc_next;
                DST_NY:  ny_reg  <= acc_next;
                DST_NZ:  nz_reg  <= acc_next;
                default: ;
            endcase
        end
        if (state_reg == ST_NX)
        begin
            nx_reg    <= den_reg - ny_reg - nz_reg;
            deg_reg   <= den_reg[ACC_W-1] || den_reg == '0;
            color_reg <= '0;
        end
        if (div_done)
        begin
            case (wi_reg)
                2'd1:    wt_reg[1] <= div_q;
                2'd2:    wt_reg[2] <= div_q;
                default: wt_reg[0] <= div_q;
            endcase
        end
        if (mix_run)
        begin
            sum_reg <= sum_next;
            if (cor_reg == 2'd2)
            begin
                case (ch_reg)
                    2'd1:    color_reg[15:8]  <= sat;
                    2'd2:    color_reg[23:16] <= sat;
                    default: color_reg[7:0]   <= sat;
                endcase
            end
        end
        if (finish)
        begin
            out_word_reg.pixel_color <= deg_reg ? '0 : color_reg;
            out_word_reg.status      <= deg_reg ? STATUS_DEGENERATE : STATUS_OK;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    a_degenerate_black: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STATUS_DEGENERATE |-> result.pixel_color == '0)
        else $error("degenerate result carries a color");

    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> item_stall)
        else $error("second word taken while a query is in flight");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> state_reg == ST_DIV && !pend_reg)
        else $error("divider started outside its phase");

    a_div_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> pend_reg)
        else $error("divider finished without a request");

endmodule

`default_nettype wire
